// ===== rtl/core/u16u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

    // Result status codes reported on the closing beat of a stream
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ODD_COUNT = 3'd1,
        ST_IN_PAIR   = 3'd2,
        ST_BAD_PAIR  = 3'd3,
        ST_LONE_LOW  = 3'd4
    } t_status;

    // Configuration register indexes
    localparam logic REG_LITTLE_ENDIAN = 1'b0;
    localparam logic REG_SKIP_BYTES    = 1'b1;

    // Surrogate ranges and UTF-8 lead/continuation marks
    localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
    localparam logic [15:0] MAX_ONE_BYTE = 16'h007F;
    localparam logic [15:0] MAX_TWO_BYTE = 16'h07FF;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam logic [7:0]  LEAD_TWO     = 8'hC0;
    localparam logic [7:0]  LEAD_THREE   = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR    = 8'hF0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;

    // Outcome of decoding one code unit
    typedef struct packed {
        logic [2:0]      count;     // UTF-8 bytes produced, 0 to 4
        logic [3:0][7:0] bytes;     // bytes[0] goes out first
        logic            err;       // an error was found in this unit
        t_status         code;      // which error
        logic            hp_next;   // high surrogate waiting after this unit
        logic [9:0]      hb_next;   // its payload bits
    } t_unit_res;

endpackage

// ===== rtl/core/u16u8_unit.sv =====
// Code unit decoder: surrogate pairing and UTF-8 encoding of one 16-bit unit.
module u16u8_unit (
    input  logic [15:0]            i_unit,
    input  logic                   i_high_pending,
    input  logic [9:0]             i_high_bits,
    output u16u8_pkg::t_unit_res   o_res
);
    import u16u8_pkg::*;

    logic        is_high;
    logic        is_low;
    logic [20:0] cp_supp;

    assign is_high = (i_unit >= HIGH_SURR_LO) && (i_unit <= HIGH_SURR_HI);
    assign is_low  = (i_unit >= LOW_SURR_LO) && (i_unit <= LOW_SURR_HI);
    assign cp_supp = SUPP_BASE + {1'b0, i_high_bits, i_unit[9:0]};

    // Pair surrogates, flag errors, encode the code point
    always_comb begin
        o_res         = '0;
        o_res.code    = ST_OK;
        o_res.hb_next = i_high_bits;
        if (i_high_pending) begin
            o_res.hp_next = 1'b0;
            if (!is_low) begin
                o_res.err  = 1'b1;
                o_res.code = ST_BAD_PAIR;
            end else begin
                o_res.count    = 3'd4;
                o_res.bytes[0] = LEAD_FOUR | {5'd0, cp_supp[20:18]};
                o_res.bytes[1] = CONT_MARK | {2'd0, cp_supp[17:12]};
                o_res.bytes[2] = CONT_MARK | {2'd0, cp_supp[11:6]};
                o_res.bytes[3] = CONT_MARK | {2'd0, cp_supp[5:0]};
            end
        end else if (is_high) begin
            o_res.hp_next = 1'b1;
            o_res.hb_next = i_unit[9:0];
        end else if (is_low) begin
            o_res.err  = 1'b1;
            o_res.code = ST_LONE_LOW;
        end else if (i_unit <= MAX_ONE_BYTE) begin
            o_res.count    = 3'd1;
            o_res.bytes[0] = i_unit[7:0];
        end else if (i_unit <= MAX_TWO_BYTE) begin
            o_res.count    = 3'd2;
            o_res.bytes[0] = LEAD_TWO | {3'd0, i_unit[10:6]};
            o_res.bytes[1] = CONT_MARK | {2'd0, i_unit[5:0]};
        end else begin
            o_res.count    = 3'd3;
            o_res.bytes[0] = LEAD_THREE | {4'd0, i_unit[15:12]};
            o_res.bytes[1] = CONT_MARK | {2'd0, i_unit[11:6]};
            o_res.bytes[2] = CONT_MARK | {2'd0, i_unit[5:0]};
        end
    end

endmodule

// ===== rtl/core/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder: stream state, result buffer, APB registers.
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_ready      i_data_byte, i_last_byte
//   result    out        o_valid / i_ready      o_utf8_byte, o_byte_valid, o_last_of_run,
//                                               o_status, o_stream_done
//   config    in         psel/penable/pwrite    paddr, pwdata, prdata, pready (always 1)
//
// Each input byte is decoded in the cycle it is accepted and its 0 to 4 results are
// loaded into a result buffer that drains one beat per cycle while i_ready is high.
// A byte that yields no result does not hold the input side; a byte that yields results
// holds it while its buffered beats drain on the output.
// The next byte is accepted in the cycle the last buffered beat is taken.
// Reset is synchronous and active low; no clearing pass.
// A stall on the result side holds the buffer and, once it is full, the input side.
module utf16_to_utf8_transcoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_utf8_byte,
    output logic                 o_byte_valid,
    output logic                 o_last_of_run,
    output u16u8_pkg::t_status   o_status,
    output logic                 o_stream_done,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import u16u8_pkg::*;

    // configuration
    logic            r_little_endian;
    logic [1:0]      r_skip_bytes;

    // stream state
    logic            r_phase;
    logic [7:0]      r_held;
    logic            r_high_pending;
    logic [9:0]      r_high_bits;
    logic [1:0]      r_skip_left;
    logic            r_err;
    t_status         r_err_code;
    logic            r_mid;

    // result buffer
    logic            r_busy;
    logic [1:0]      r_idx;
    logic [1:0]      r_last_idx;
    logic [3:0][7:0] r_bytes;
    logic            r_bv;
    t_status         r_status;
    logic            r_end;

    // next values
    logic            n_phase;
    logic [7:0]      n_held;
    logic            n_high_pending;
    logic [9:0]      n_high_bits;
    logic [1:0]      n_skip_left;
    logic            n_err;
    t_status         n_err_code;
    logic            n_mid;
    logic [2:0]      n_count;
    logic [3:0][7:0] n_bytes;
    logic            n_bv;
    t_status         n_status;
    logic            n_end;

    logic            in_fire;
    logic            out_fire;
    logic            cfg_wr;
    logic            drain_last;
    logic [15:0]     unit;
    t_unit_res       unit_res;
    logic            odd;
    t_status         end_status;

    assign in_fire    = i_valid && o_ready;
    assign out_fire   = o_valid && i_ready;
    assign drain_last = out_fire && (r_idx == r_last_idx);
    assign o_ready    = !r_busy || drain_last;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    // Assemble the code unit in the configured byte order
    assign unit = r_little_endian ? {i_data_byte, r_held} : {r_held, i_data_byte};

    u16u8_unit u_unit (
        .i_unit         (unit),
        .i_high_pending (r_high_pending),
        .i_high_bits    (r_high_bits),
        .o_res          (unit_res)
    );

    // Advance stream state for the incoming byte
    always_comb begin
        n_phase        = r_phase;
        n_held         = r_held;
        n_high_pending = r_high_pending;
        n_high_bits    = r_high_bits;
        n_skip_left    = r_skip_left;
        n_err          = r_err;
        n_err_code     = r_err_code;
        n_mid          = r_mid;
        n_count        = 3'd0;
        n_bytes        = unit_res.bytes;
        n_bv           = 1'b1;
        n_status       = ST_OK;
        n_end          = 1'b0;
        odd            = 1'b0;
        end_status     = ST_OK;
        if (r_err) begin
            n_count = 3'd0;
        end else if (r_skip_left != 2'd0) begin
            n_skip_left = r_skip_left - 2'd1;
        end else if (!r_phase) begin
            n_held  = i_data_byte;
            n_phase = 1'b1;
        end else begin
            n_phase        = 1'b0;
            n_count        = unit_res.count;
            n_high_pending = unit_res.hp_next;
            n_high_bits    = unit_res.hb_next;
            if (unit_res.err) begin
                n_err      = 1'b1;
                n_err_code = unit_res.code;
            end
        end

        // Close the stream on its last byte
        if (!i_last_byte) begin
            n_mid = 1'b1;
        end else begin
            odd = n_phase || n_skip_left[0];
            if (odd) begin
                end_status = ST_ODD_COUNT;
            end else if (n_err) begin
                end_status = n_err_code;
            end else if (n_high_pending) begin
                end_status = ST_IN_PAIR;
            end
            n_end = 1'b1;
            if ((end_status != ST_OK) || (n_count == 3'd0)) begin
                n_count  = 3'd1;
                n_bytes  = '0;
                n_bv     = 1'b0;
                n_status = end_status;
            end
            n_phase        = 1'b0;
            n_held         = 8'd0;
            n_high_pending = 1'b0;
            n_high_bits    = 10'd0;
            n_err          = 1'b0;
            n_err_code     = ST_OK;
            n_mid          = 1'b0;
            n_skip_left    = r_skip_bytes;
        end
    end

    // Hold stream state, result buffer and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_little_endian <= 1'b1;
            r_skip_bytes    <= 2'd0;
            r_phase         <= 1'b0;
            r_held          <= 8'd0;
            r_high_pending  <= 1'b0;
            r_high_bits     <= 10'd0;
            r_skip_left     <= 2'd0;
            r_err           <= 1'b0;
            r_err_code      <= ST_OK;
            r_mid           <= 1'b0;
            r_busy          <= 1'b0;
            r_idx           <= 2'd0;
            r_last_idx      <= 2'd0;
        end else begin
            // Load a new run of beats, else step through the buffered one
            if (in_fire && (n_count != 3'd0)) begin
                r_busy     <= 1'b1;
                r_idx      <= 2'd0;
                r_last_idx <= 2'(n_count - 3'd1);
            end else if (out_fire) begin
                if (r_idx == r_last_idx) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
            if (in_fire) begin
                r_phase        <= n_phase;
                r_held         <= n_held;
                r_high_pending <= n_high_pending;
                r_high_bits    <= n_high_bits;
                r_skip_left    <= n_skip_left;
                r_err          <= n_err;
                r_err_code     <= n_err_code;
                r_mid          <= n_mid;
            end
            if (cfg_wr) begin
                case (paddr[2])
                    REG_LITTLE_ENDIAN: begin
                        r_little_endian <= pwdata[0];
                    end
                    REG_SKIP_BYTES: begin
                        r_skip_bytes <= pwdata[1:0];
                        if (!r_mid) begin
                            r_skip_left <= pwdata[1:0];
                        end
                    end
                    default: begin
                        r_skip_bytes <= r_skip_bytes;
                    end
                endcase
            end
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (in_fire && (n_count != 3'd0)) begin
            r_bytes  <= n_bytes;
            r_bv     <= n_bv;
            r_status <= n_status;
            r_end    <= n_end;
        end
    end

    // Drive the current beat
    assign o_valid       = r_busy;
    assign o_utf8_byte   = r_bytes[r_idx];
    assign o_byte_valid  = r_bv;
    assign o_last_of_run = (r_idx == r_last_idx);
    assign o_status      = r_status;
    assign o_stream_done = r_end && (r_idx == r_last_idx);

    // Register read back
    always_comb begin
        case (paddr[2])
            REG_LITTLE_ENDIAN: prdata = {31'd0, r_little_endian};
            REG_SKIP_BYTES:    prdata = {30'd0, r_skip_bytes};
            default:           prdata = 32'd0;
        endcase
    end

    // Checks on the result buffer and stream state
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stream_done) |-> o_last_of_run)
        else $error("stream_done without last_of_run");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (!o_byte_valid && o_stream_done))
        else $error("error status on a data beat");

    a_err_no_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_err && r_high_pending))
        else $error("high surrogate pending after an error");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_last_byte) |=> (!r_mid && !r_phase && !r_err && !r_high_pending))
        else $error("stream state not restarted after last byte");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_last_idx))
        else $error("result index past last buffered beat");

endmodule

// ===== tb/sv/u16u8_tb_pkg.sv =====
`timescale 1ns / 1ps
// UTF-8 beat type and the scoreboard that predicts and checks transcoder output.
package u16u8_tb_pkg;
    import u16u8_pkg::*;

    // One result beat as seen on the output channel
    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       byte_valid;
        logic       last_of_run;
        t_status    status;
        logic       stream_done;
    } t_utf8_beat;

    class transcode_scoreboard;
        // register copies
        bit         le_order;
        bit [1:0]   skip_count;
        // stream decode state
        bit         byte_odd;
        bit [7:0]   held_byte;
        bit         high_waiting;
        bit [9:0]   high_payload;
        bit [1:0]   skip_left;
        bit         error_seen;
        t_status    err_status;
        bit         in_stream;
        // UTF-8 bytes of the unit just decoded, and beats still owed by the block
        logic [7:0] unit_utf8[$];
        t_utf8_beat expected_utf8[$];
        int         beats_checked;
        int         mismatch_count;

        function new();
            le_order       = 1'b1;
            skip_count     = 2'd0;
            beats_checked  = 0;
            mismatch_count = 0;
            restart_stream();
        endfunction

        function void restart_stream();
            byte_odd     = 1'b0;
            held_byte    = 8'd0;
            high_waiting = 1'b0;
            high_payload = 10'd0;
            error_seen   = 1'b0;
            err_status   = ST_OK;
            in_stream    = 1'b0;
            skip_left    = skip_count;
        endfunction

        // Mirror a register write; skip count reloads at once only between streams
        function void write_reg(logic idx, logic [31:0] value);
            if (idx == REG_LITTLE_ENDIAN) begin
                le_order = value[0];
            end else begin
                skip_count = value[1:0];
                if (!in_stream) skip_left = skip_count;
            end
        endfunction

        function int pending();
            return expected_utf8.size();
        endfunction

        // Add one byte to the UTF-8 form of the current unit
        function void append_utf8(logic [7:0] b);
            unit_utf8 = {unit_utf8, b};
        endfunction

        // Append the UTF-8 form of one code point
        function void encode_code_point(logic [20:0] cp);
            if (cp <= 21'h7F) begin
                append_utf8(cp[7:0]);
            end else if (cp <= 21'h7FF) begin
                append_utf8(LEAD_TWO | {3'b000, cp[10:6]});
                append_utf8(CONT_MARK | {2'b00, cp[5:0]});
            end else if (cp <= 21'hFFFF) begin
                append_utf8(LEAD_THREE | {4'b0000, cp[15:12]});
                append_utf8(CONT_MARK | {2'b00, cp[11:6]});
                append_utf8(CONT_MARK | {2'b00, cp[5:0]});
            end else begin
                append_utf8(LEAD_FOUR | {5'b00000, cp[20:18]});
                append_utf8(CONT_MARK | {2'b00, cp[17:12]});
                append_utf8(CONT_MARK | {2'b00, cp[11:6]});
                append_utf8(CONT_MARK | {2'b00, cp[5:0]});
            end
        endfunction

        function void push_beat(logic [7:0] b, logic valid, logic last, t_status st,
                                logic done);
            t_utf8_beat beat;
            beat.utf8_byte   = b;
            beat.byte_valid  = valid;
            beat.last_of_run = last;
            beat.status      = st;
            beat.stream_done = done;
            expected_utf8 = {expected_utf8, beat};
        endfunction

        // Predict the beats caused by one accepted UTF-16 byte
        function void note_utf16_byte(logic [7:0] b, logic last);
            logic [15:0] unit;
            t_status     st;
            int          n;
            unit_utf8.delete();
            if (!error_seen) begin
                if (skip_left != 2'd0) begin
                    skip_left = skip_left - 2'd1;
                end else if (!byte_odd) begin
                    held_byte = b;
                    byte_odd  = 1'b1;
                end else begin
                    unit     = le_order ? {b, held_byte} : {held_byte, b};
                    byte_odd = 1'b0;
                    if (high_waiting) begin
                        high_waiting = 1'b0;
                        if (unit < LOW_SURR_LO || unit > LOW_SURR_HI) begin
                            error_seen = 1'b1;
                            err_status = ST_BAD_PAIR;
                        end else begin
                            encode_code_point(SUPP_BASE + {1'b0, high_payload, unit[9:0]});
                        end
                    end else if (unit >= HIGH_SURR_LO && unit <= HIGH_SURR_HI) begin
                        high_waiting = 1'b1;
                        high_payload = unit[9:0];
                    end else if (unit >= LOW_SURR_LO && unit <= LOW_SURR_HI) begin
                        error_seen = 1'b1;
                        err_status = ST_LONE_LOW;
                    end else begin
                        encode_code_point({5'd0, unit});
                    end
                end
            end
            n = unit_utf8.size();

            if (!last) begin
                in_stream = 1'b1;
                for (int k = 0; k < n; k++)
                    push_beat(unit_utf8[k], 1'b1, k == n - 1, ST_OK, 1'b0);
            end else begin
                // odd count wins, then the recorded error, then a dangling high surrogate
                st = ST_OK;
                if (byte_odd || skip_left[0]) st = ST_ODD_COUNT;
                else if (error_seen)          st = err_status;
                else if (high_waiting)        st = ST_IN_PAIR;

                if (st != ST_OK || n == 0) begin
                    push_beat(8'd0, 1'b0, 1'b1, st, 1'b1);
                end else begin
                    for (int k = 0; k < n; k++)
                        push_beat(unit_utf8[k], 1'b1, k == n - 1, ST_OK, k == n - 1);
                end
                restart_stream();
            end
        endfunction

        // Compare one output beat against the oldest prediction
        function void check_utf8_beat(t_utf8_beat got);
            t_utf8_beat want;
            bit         bad;
            beats_checked++;
            if (expected_utf8.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] beat %0d not expected: byte=%02h valid=%0b last=%0b %s",
                             $time, beats_checked, got.utf8_byte, got.byte_valid,
                             got.last_of_run,
                             $sformatf("status=%0d done=%0b", got.status, got.stream_done));
            end else begin
                want = expected_utf8.pop_front();
                bad = (got.utf8_byte !== want.utf8_byte)
                    || (got.byte_valid !== want.byte_valid)
                    || (got.last_of_run !== want.last_of_run) || (got.status !== want.status)
                    || (got.stream_done !== want.stream_done);
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("[%0t] beat %0d mismatch:", $time, beats_checked);
                        $display("    expected byte=%02h valid=%0b last=%0b status=%0d done=%0b",
                                 want.utf8_byte, want.byte_valid, want.last_of_run,
                                 want.status, want.stream_done);
                        $display("    got      byte=%02h valid=%0b last=%0b status=%0d done=%0b",
                                 got.utf8_byte, got.byte_valid, got.last_of_run,
                                 got.status, got.stream_done);
                    end
                end
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top-level testbench: drives UTF-16 byte streams and register writes, checks UTF-8 beats.
module tb_top;
    import u16u8_pkg::*;
    import u16u8_tb_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    localparam int CYCLE_LIMIT  = 500000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_ready     = 1'b1;
    logic [7:0]  o_utf8_byte;
    logic        o_byte_valid;
    logic        o_last_of_run;
    t_status     o_status;
    logic        o_stream_done;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = 3'd0;
    logic [31:0] pwdata      = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    transcode_scoreboard sb;
    logic [7:0]  stream_q[$];
    bit          cur_le     = 1'b1;
    bit [1:0]    cur_skip   = 2'd0;
    bit          idle_on    = 1'b1;
    int          bytes_sent = 0;
    int          ready_hold = 0;
    int          cycle_count = 0;

    utf16_to_utf8_transcoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_utf8_byte   (o_utf8_byte),
        .o_byte_valid  (o_byte_valid),
        .o_last_of_run (o_last_of_run),
        .o_status      (o_status),
        .o_stream_done (o_stream_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** utf16_to_utf8_transcoder: FAILED **");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < 25) begin
            ready_hold = pick_idle_len() - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Record input beats first, then check output beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_utf16_byte(i_data_byte, i_last_byte);
            if (o_valid && i_ready)
                sb.check_utf8_beat(t_utf8_beat'({o_utf8_byte, o_byte_valid, o_last_of_run,
                                                 o_status, o_stream_done}));
        end
    end

    // Present one byte, hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 35) ? pick_idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
    endtask

    // Drop valid and wait until every predicted beat has come out
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {30'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, {30'd0, value});
        if (idx == REG_LITTLE_ENDIAN) cur_le = value[0];
        else cur_skip = value;
    endtask

    // Add one byte to the end of the stream under construction
    function automatic void append_byte(logic [7:0] b);
        stream_q = {stream_q, b};
    endfunction

    // Append one code unit in the current byte order
    function automatic void push_unit(logic [15:0] u);
        if (cur_le) begin
            append_byte(u[7:0]);
            append_byte(u[15:8]);
        end else begin
            append_byte(u[15:8]);
            append_byte(u[7:0]);
        end
    endfunction

    function automatic logic [15:0] rand_scalar();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(16'h0000, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [15:0] rand_high();
        return HIGH_SURR_LO | {6'd0, 10'($urandom_range(0, 1023))};
    endfunction

    function automatic logic [15:0] rand_low();
        return LOW_SURR_LO | {6'd0, 10'($urandom_range(0, 1023))};
    endfunction

    // Append one well-formed code point: a scalar unit or a surrogate pair
    function automatic void push_code_point();
        if ($urandom_range(0, 99) < 20) begin
            push_unit(rand_high());
            push_unit(rand_low());
        end else begin
            push_unit(rand_scalar());
        end
    endfunction

    // Build a stream: BOM bytes, then mostly valid content, sometimes broken
    task automatic build_random_stream();
        int n_cp;
        int pos;
        stream_q.delete();
        repeat (cur_skip) append_byte(8'($urandom_range(0, 255)));
        n_cp = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
        if ($urandom_range(0, 99) < 78) begin
            repeat (n_cp) push_code_point();
        end else begin
            case ($urandom_range(0, 5))
                0: begin
                    // lone low surrogate somewhere in the run
                    pos = $urandom_range(0, n_cp - 1);
                    for (int i = 0; i < n_cp; i++) begin
                        if (i == pos) push_unit(rand_low());
                        else push_code_point();
                    end
                end
                1: begin
                    // high surrogate followed by a scalar or another high
                    repeat ($urandom_range(0, 2)) push_code_point();
                    push_unit(rand_high());
                    push_unit($urandom_range(0, 1) ? rand_scalar() : rand_high());
                    repeat ($urandom_range(0, 2)) push_code_point();
                end
                2: begin
                    // ends while a low surrogate is still owed
                    repeat (n_cp - 1) push_code_point();
                    push_unit(rand_high());
                end
                3: begin
                    // one stray byte makes the count odd
                    repeat (n_cp) push_code_point();
                    append_byte(8'($urandom_range(0, 255)));
                end
                4: begin
                    // stream no longer than the BOM skip
                    stream_q.delete();
                    repeat ($urandom_range(1, (cur_skip > 0) ? cur_skip : 1))
                        append_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    // raw noise
                    repeat ($urandom_range(1, 10)) append_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    initial begin
        int random_start;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // length bounds of each UTF-8 form, little endian, no skip
        stream_q.delete();
        push_unit(16'h007F);
        push_unit(16'h0080);
        push_unit(16'h07FF);
        push_unit(16'h0800);
        push_unit(16'hFFFF);
        send_stream();
        // NUL, then the highest supplementary code point
        stream_q.delete();
        push_unit(16'h0000);
        push_unit(16'hDBFF);
        push_unit(16'hDFFF);
        send_stream();
        // lone low surrogate; the unit after it is dropped
        stream_q.delete();
        push_unit(16'hDC00);
        push_unit(16'h0041);
        send_stream();
        // high surrogate followed by another high: invalid pair
        stream_q.delete();
        push_unit(16'hD800);
        push_unit(16'hD800);
        send_stream();
        // stream ends on a high surrogate
        stream_q.delete();
        push_unit(16'hD800);
        send_stream();

        // big endian with the widest skip
        settle();
        apb_write(REG_LITTLE_ENDIAN, 2'd0);
        apb_write(REG_SKIP_BYTES, 2'd3);
        stream_q = '{8'hFE, 8'hFF, 8'h00};
        push_unit(16'h20AC);
        send_stream();
        // two bytes under a skip of three: the missing byte makes the count odd
        stream_q = '{8'hFF, 8'hFE};
        send_stream();
        // change both registers while a unit is half received
        stream_q = '{8'h11, 8'h22, 8'h33, 8'hAC};
        foreach (stream_q[i]) send_byte(stream_q[i], 1'b0);
        settle();
        apb_write(REG_LITTLE_ENDIAN, 2'd1);
        apb_write(REG_SKIP_BYTES, 2'd0);
        send_byte(8'h20, 1'b1);

        // random phases: new settings, then a batch of streams
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_ITEMS) begin
            settle();
            apb_write(REG_LITTLE_ENDIAN, 2'($urandom_range(0, 1)));
            apb_write(REG_SKIP_BYTES, 2'($urandom_range(0, 3)));
            idle_on = ($urandom_range(0, 4) != 0);
            repeat ($urandom_range(3, 8)) begin
                build_random_stream();
                send_stream();
            end
        end

        settle();
        repeat (16) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("** utf16_to_utf8_transcoder: PASSED **");
        end else begin
            $display("** utf16_to_utf8_transcoder: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/u16u8_pkg.sv
rtl/core/u16u8_unit.sv
rtl/core/utf16_to_utf8_transcoder.sv
tb/sv/u16u8_tb_pkg.sv
tb/sv/tb_top.sv
